// ----- design/ibrd_pkg.sv -----
// Shared types and constants for the indexed bitmap RLE decoder.
package ibrd_pkg;

    // Opcode bytes of the encoded stream.
    localparam logic [7:0] OP_BASE    = 8'hFB;
    localparam logic [7:0] OP_TRANSP  = 8'hFC;
    localparam logic [7:0] OP_SOLID   = 8'hFD;
    localparam logic [7:0] OP_ROW_END = 8'hFE;
    localparam logic [7:0] OP_IMG_END = 8'hFF;

    // Field widths.
    localparam int DIM_W   = 17;
    localparam int COLOR_W = 8;
    localparam int FMT_W   = 4;
    localparam logic [FMT_W-1:0] FMT_MAX = 4'd8;
    localparam logic [DIM_W-1:0] COUNT_SAT = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    // Command kinds passed from the parser to the run stage.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_RUN,
        CMD_PAD,
        CMD_FILL,
        CMD_FLAG
    } cmd_kind_t;

    // One parsed command.
    typedef struct packed {
        cmd_kind_t            kind;
        logic                 restart;
        logic [COLOR_W-1:0]   value;
        logic [7:0]           len;
        logic [DIM_W-1:0]     rows_left;
        logic                 last;
        logic [COLOR_W-1:0]   max_color;
    } cmd_t;

endpackage

// ----- design/indexed_bitmap_rle_decoder_top.sv -----
// Top level of the indexed bitmap RLE decoder: configuration port and channel wiring.
//
// The encoded bitmap enters one byte per word on the s_ channel: s_tdata carries the
// byte, s_tuser marks the first byte of an image. Each byte yields at most one run
// word on the m_ channel: m_tdata holds pixel value, clipped run count and maximum
// color so far; m_tlast marks the end of an image; m_tuser flags an oversized image.
// Image width, height and code format are set over the APB port at 0x0, 0x4 and 0x8
// while the decoder is idle; the oversize flag is recomputed at the write itself.
// An accepted byte's command passes from the parser into the command queue, and the
// run stage moves it from the queue into the output register. Throughput is one byte
// per cycle; the parser and the run stage each complete a word per cycle, and the
// command queue lets the parser keep accepting bytes while the receiver stalls, until
// the queue fills (QUEUE_DEPTH commands) and s_tready drops. Bytes that yield no run
// word take a queue slot when they start an image or carry a run that the run stage
// drops (zero length or past the row end). Reset clears the configuration to zero,
// empties the queue and output register, and leaves the parser awaiting an image's first byte.
module indexed_bitmap_rle_decoder_top #(
    parameter int MAX_PIXELS  = 65536,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_image
    // Run words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel_value, [24:8] run_count, [32:25] max_color
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] size_error
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ibrd_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [ibrd_pkg::FMT_W-1:0] format_reg;
    logic                       too_large_reg;
    logic                       cfg_wr;
    logic [1:0]                 reg_index;
    logic [2*ibrd_pkg::DIM_W-1:0] size_prod;

    logic           accept;
    logic           cmd_valid;
    ibrd_pkg::cmd_t cmd;
    logic           q_full, q_not_empty, q_pop;
    ibrd_pkg::cmd_t q_head;

    logic [7:0]                 pixel_value, max_color;
    logic [ibrd_pkg::DIM_W-1:0] run_count;
    logic                       size_error;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // Product of the dimensions with the register being written taking its new value.
    always_comb begin
        size_prod = width_reg * height_reg;
        if (reg_index == ibrd_pkg::REG_WIDTH) begin
            size_prod = pwdata[ibrd_pkg::DIM_W-1:0] * height_reg;
        end else if (reg_index == ibrd_pkg::REG_HEIGHT) begin
            size_prod = width_reg * pwdata[ibrd_pkg::DIM_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= '0;
            height_reg    <= '0;
            format_reg    <= '0;
            too_large_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_index)
                ibrd_pkg::REG_WIDTH:  width_reg  <= pwdata[ibrd_pkg::DIM_W-1:0];
                ibrd_pkg::REG_HEIGHT: height_reg <= pwdata[ibrd_pkg::DIM_W-1:0];
                ibrd_pkg::REG_FORMAT: format_reg <= pwdata[ibrd_pkg::FMT_W-1:0];
                default: ;
            endcase
            too_large_reg <= (size_prod > (2*ibrd_pkg::DIM_W)'(MAX_PIXELS));
        end
    end

    // Register read back.
    always_comb begin
        case (reg_index)
            ibrd_pkg::REG_WIDTH:  prdata = {15'd0, width_reg};
            ibrd_pkg::REG_HEIGHT: prdata = {15'd0, height_reg};
            ibrd_pkg::REG_FORMAT: prdata = {28'd0, format_reg};
            default:              prdata = '0;
        endcase
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    ibrd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata),
        .first_of_image (s_tuser[0]),
        .image_height   (height_reg),
        .code_format    (format_reg),
        .too_large      (too_large_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd)
    );

    ibrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_valid),
        .push_data (cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ibrd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_not_empty),
        .head          (q_head),
        .pop           (q_pop),
        .image_width   (width_reg),
        .too_large     (too_large_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .pixel_value   (pixel_value),
        .run_count     (run_count),
        .last_of_image (m_tlast),
        .max_color     (max_color),
        .size_error    (size_error)
    );

    assign m_tdata = {7'd0, max_color, run_count, pixel_value};
    assign m_tuser = size_error;

endmodule

// ----- design/ibrd_front.sv -----
// Byte parser: tracks opcodes, color base, rows and maximum color; emits commands.
module ibrd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        first_of_image,
    input  logic [ibrd_pkg::DIM_W-1:0]  image_height,
    input  logic [ibrd_pkg::FMT_W-1:0]  code_format,
    input  logic                        too_large,
    output logic                        cmd_valid,
    output ibrd_pkg::cmd_t              cmd
);

    typedef enum logic [2:0] {
        PH_ROW_START,
        PH_OPCODE,
        PH_BASE_LO,
        PH_BASE_HI,
        PH_T_COUNT,
        PH_S_COUNT,
        PH_S_COLOR
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [ibrd_pkg::DIM_W-1:0] row_reg, row_next;
    logic [15:0]                base_reg, base_next;
    logic [7:0]                 max_reg, max_next;
    logic [7:0]                 pend_reg, pend_next;
    logic [7:0]                 low_reg, low_next;
    logic                       done_reg, done_next;

    // Parse one byte against the current state.
    always_comb begin
        logic [ibrd_pkg::FMT_W-1:0] fmt;
        logic [8:0]                 mask;
        logic [7:0]                 shifted;
        logic [7:0]                 lit_color;
        logic [7:0]                 lit_len;
        logic [ibrd_pkg::DIM_W-1:0] row_inc;

        phase_next = phase_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        max_next   = max_reg;
        pend_next  = pend_reg;
        low_next   = low_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.kind   = ibrd_pkg::CMD_NOP;
        cmd.restart = first_of_image;

        fmt = (code_format > ibrd_pkg::FMT_MAX) ? ibrd_pkg::FMT_MAX : code_format;
        mask = (9'd1 << fmt) - 9'd1;
        shifted = data_byte >> fmt;
        lit_color = base_reg[7:0] + shifted;
        lit_len = (data_byte & mask[7:0]) + 8'd1;
        row_inc = row_reg + 17'd1;

        // A new image clears the parser state first.
        if (first_of_image) begin
            phase_next = PH_ROW_START;
            row_next   = '0;
            base_next  = '0;
            max_next   = '0;
            pend_next  = '0;
            low_next   = '0;
            done_next  = 1'b0;
            lit_color  = shifted;
            row_inc    = 17'd1;
            if (too_large || image_height == '0) begin
                done_next = 1'b1;
                cmd.kind  = ibrd_pkg::CMD_FLAG;
                cmd.last  = 1'b1;
            end
        end

        if (!done_next) begin
            case (first_of_image ? PH_ROW_START : phase_reg)
                PH_BASE_LO: begin
                    low_next   = data_byte;
                    phase_next = PH_BASE_HI;
                end
                PH_BASE_HI: begin
                    base_next  = {data_byte, low_reg};
                    phase_next = PH_OPCODE;
                end
                PH_T_COUNT: begin
                    phase_next = PH_OPCODE;
                    cmd.kind   = ibrd_pkg::CMD_RUN;
                    cmd.len    = data_byte + 8'd1;
                end
                PH_S_COUNT: begin
                    pend_next  = data_byte + 8'd1;
                    phase_next = PH_S_COLOR;
                end
                PH_S_COLOR: begin
                    phase_next = PH_OPCODE;
                    if (data_byte > max_reg) begin
                        max_next = data_byte;
                    end
                    cmd.kind  = ibrd_pkg::CMD_RUN;
                    cmd.value = data_byte;
                    cmd.len   = pend_reg;
                end
                default: begin
                    if ((first_of_image || phase_reg == PH_ROW_START)
                        && data_byte == ibrd_pkg::OP_IMG_END) begin
                        // End of image: fill the remaining rows.
                        done_next = 1'b1;
                        cmd.kind  = ibrd_pkg::CMD_FILL;
                        cmd.last  = 1'b1;
                        if (row_next < image_height) begin
                            cmd.rows_left = image_height - row_next;
                        end
                    end else begin
                        phase_next = PH_OPCODE;
                        case (data_byte)
                            ibrd_pkg::OP_BASE:   phase_next = PH_BASE_LO;
                            ibrd_pkg::OP_TRANSP: phase_next = PH_T_COUNT;
                            ibrd_pkg::OP_SOLID:  phase_next = PH_S_COUNT;
                            ibrd_pkg::OP_ROW_END: begin
                                row_next   = row_inc;
                                phase_next = PH_ROW_START;
                                cmd.kind   = ibrd_pkg::CMD_PAD;
                                cmd.last   = (row_inc >= image_height);
                                done_next  = (row_inc >= image_height);
                            end
                            default: begin
                                // Literal byte: color index and run length.
                                if (lit_color > max_next) begin
                                    max_next = lit_color;
                                end
                                cmd.kind  = ibrd_pkg::CMD_RUN;
                                cmd.value = lit_color;
                                cmd.len   = lit_len;
                            end
                        endcase
                    end
                end
            endcase
        end

        cmd.max_color = max_next;
        cmd_valid = accept && (first_of_image || cmd.kind != ibrd_pkg::CMD_NOP);
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ROW_START;
            row_reg   <= '0;
            base_reg  <= '0;
            max_reg   <= '0;
            pend_reg  <= '0;
            low_reg   <= '0;
            done_reg  <= 1'b1;
        end else if (accept) begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            max_reg   <= max_next;
            pend_reg  <= pend_next;
            low_reg   <= low_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ----- design/ibrd_queue.sv -----
// Small command queue between the parser and the run stage.
module ibrd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ibrd_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ibrd_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ibrd_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty)) else $error("pop from empty queue");

endmodule

// ----- design/ibrd_back.sv -----
// Run stage: clips runs to the row, computes pads and fills, holds the output word.
module ibrd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  ibrd_pkg::cmd_t              head,
    output logic                        pop,
    input  logic [ibrd_pkg::DIM_W-1:0]  image_width,
    input  logic                        too_large,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  pixel_value,
    output logic [ibrd_pkg::DIM_W-1:0]  run_count,
    output logic                        last_of_image,
    output logic [7:0]                  max_color,
    output logic                        size_error
);

    logic [ibrd_pkg::DIM_W-1:0] col_reg, col_next;
    logic                       m_valid_reg;
    logic [7:0]                 pixel_reg, max_reg;
    logic [ibrd_pkg::DIM_W-1:0] count_reg;
    logic                       last_reg, serr_reg;
    logic                       emit;
    logic [ibrd_pkg::DIM_W-1:0] count_new;

    assign pop = head_valid && (!m_valid_reg || m_tready);

    // Carry out the command at the head of the queue.
    always_comb begin
        logic [ibrd_pkg::DIM_W-1:0] col_eff;
        logic [ibrd_pkg::DIM_W:0]   sum;
        logic [2*ibrd_pkg::DIM_W-1:0] prod;

        col_eff   = head.restart ? '0 : col_reg;
        col_next  = col_eff;
        emit      = 1'b0;
        count_new = '0;
        sum       = {1'b0, col_eff} + {10'd0, head.len};
        prod      = head.rows_left * image_width;

        case (head.kind)
            ibrd_pkg::CMD_RUN: begin
                if (head.len != '0 && col_eff < image_width) begin
                    emit = 1'b1;
                    if (sum > {1'b0, image_width}) begin
                        count_new = image_width - col_eff;
                        col_next  = image_width;
                    end else begin
                        count_new = {9'd0, head.len};
                        col_next  = sum[ibrd_pkg::DIM_W-1:0];
                    end
                end
            end
            ibrd_pkg::CMD_PAD: begin
                emit     = 1'b1;
                col_next = '0;
                if (col_eff < image_width) begin
                    count_new = image_width - col_eff;
                end
            end
            ibrd_pkg::CMD_FILL: begin
                emit = 1'b1;
                if (prod > {17'd0, ibrd_pkg::COUNT_SAT}) begin
                    count_new = ibrd_pkg::COUNT_SAT;
                end else begin
                    count_new = prod[ibrd_pkg::DIM_W-1:0];
                end
            end
            ibrd_pkg::CMD_FLAG: begin
                emit     = 1'b1;
                col_next = '0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Column and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                col_reg <= col_next;
            end
            if (pop && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            pixel_reg <= head.value;
            count_reg <= count_new;
            last_reg  <= head.last;
            max_reg   <= head.max_color;
            serr_reg  <= too_large;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign pixel_value   = pixel_reg;
    assign run_count     = count_reg;
    assign last_of_image = last_reg;
    assign max_color     = max_reg;
    assign size_error    = serr_reg;

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && emit && head.kind == ibrd_pkg::CMD_RUN |=> col_reg <= image_width)
        else $error("column past row end after run");
    a_fill_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (head.kind == ibrd_pkg::CMD_FILL || head.kind == ibrd_pkg::CMD_FLAG)
        |=> m_valid_reg && last_reg) else $error("image end word without last");
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && emit && head.kind == ibrd_pkg::CMD_RUN |=> count_reg != '0 && !last_reg)
        else $error("empty run word");

endmodule
